[src/lkv_pkg.sv]
package lkv_pkg;

   // Table geometry.
   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   // Field widths.
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Capacity after reset, and the value returned on a get that misses.
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type               opcode;
      logic signed [KEY_W-1:0]  lookup_key;
      logic signed [VAL_W-1:0]  store_value;
   } req_word_type;

   typedef struct packed {
      logic                     found;
      logic signed [VAL_W-1:0]  read_value;
      logic                     evicted;
   } rsp_word_type;

   typedef logic [MAX_ENTRIES-1:0][KEY_W-1:0] key_array_type;
   typedef logic [MAX_ENTRIES-1:0][VAL_W-1:0] value_array_type;
   typedef logic [MAX_ENTRIES-1:0][IDX_W-1:0] rank_array_type;

   // What the tag compare tells the update logic.
   typedef struct packed {
      logic [MAX_ENTRIES-1:0] hit_vec;
      logic                   found;
      logic [IDX_W-1:0]       hit_rank;
      logic [VAL_W-1:0]       hit_value;
   } match_type;

endpackage

[src/lkv_match.sv]
module lkv_match
   import lkv_pkg::*;
(
   input  logic [KEY_W-1:0]       lookup_key,
   input  key_array_type          entry_key,
   input  value_array_type        entry_value,
   input  rank_array_type         entry_rank,
   input  logic [MAX_ENTRIES-1:0] entry_valid,
   output match_type              match
);

   logic [MAX_ENTRIES-1:0] hit_vec;
   logic [IDX_W-1:0]       hit_rank;
   logic [VAL_W-1:0]       hit_value;

   // Parallel tag compare against every valid entry.
   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_vec[i] = entry_valid[i] && (entry_key[i] == lookup_key);
      end
   end

   // Keys are unique among valid entries, so at most one hit bit is set and an
   // AND-OR select picks its rank and value.
   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_rank  = hit_rank  | (entry_rank[i]  & {IDX_W{hit_vec[i]}});
         hit_value = hit_value | (entry_value[i] & {VAL_W{hit_vec[i]}});
      end
   end

   assign match.hit_vec   = hit_vec;
   assign match.found     = |hit_vec;
   assign match.hit_rank  = hit_rank;
   assign match.hit_value = hit_value;

endmodule

[src/lkv_table.sv]
module lkv_table
   import lkv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             access_en,
   input  req_word_type     access_word,
   input  logic [CNT_W-1:0] capacity,
   output rsp_word_type     result_word
);

   key_array_type          entry_key_ff;
   key_array_type          entry_key_in;
   value_array_type        entry_value_ff;
   value_array_type        entry_value_in;
   rank_array_type         entry_rank_ff;
   rank_array_type         entry_rank_in;
   logic [MAX_ENTRIES-1:0] entry_valid_ff;
   logic [MAX_ENTRIES-1:0] entry_valid_in;
   logic [CNT_W-1:0]       used_ff;
   logic [CNT_W-1:0]       used_in;

   match_type              match;
   logic                   need_evict;
   logic [IDX_W-1:0]       oldest_rank;
   logic [CNT_W-1:0]       used_minus_one;
   logic [MAX_ENTRIES-1:0] evict_vec;
   logic [MAX_ENTRIES-1:0] valid_mid;
   logic [MAX_ENTRIES-1:0] free_vec;
   logic [MAX_ENTRIES-1:0] slot_vec;
   logic                   did_evict;

   lkv_match u_match (
      .lookup_key  (access_word.lookup_key),
      .entry_key   (entry_key_ff),
      .entry_value (entry_value_ff),
      .entry_rank  (entry_rank_ff),
      .entry_valid (entry_valid_ff),
      .match       (match)
   );

   // Victim choice: ranks of valid entries are a permutation of 0 to used-1,
   // so the least recent entry is the one whose rank equals used-1.
   assign need_evict     = (used_ff >= capacity);
   assign used_minus_one = used_ff - CNT_W'(1);
   assign oldest_rank    = used_minus_one[IDX_W-1:0];

   always_comb begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         evict_vec[i] = need_evict && entry_valid_ff[i] && (entry_rank_ff[i] == oldest_rank);
      end
   end

   // Free slot: lowest numbered entry left invalid after any eviction.
   assign valid_mid = entry_valid_ff & ~evict_vec;
   assign free_vec  = ~valid_mid;
   assign slot_vec  = free_vec & (~free_vec + MAX_ENTRIES'(1));
   assign did_evict = |evict_vec;

   // Next state of the entry table for the word being processed.
   always_comb begin
      entry_key_in   = entry_key_ff;
      entry_value_in = entry_value_ff;
      entry_rank_in  = entry_rank_ff;
      entry_valid_in = entry_valid_ff;
      used_in        = used_ff;
      if (access_en) begin
         if (match.found) begin
            // Hit on get or put: the entry becomes the most recent.
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (match.hit_vec[i]) begin
                  entry_rank_in[i] = '0;
                  if (access_word.opcode == OP_PUT) begin
                     entry_value_in[i] = access_word.store_value;
                  end
               end else if (entry_valid_ff[i] && (entry_rank_ff[i] < match.hit_rank)) begin
                  entry_rank_in[i] = entry_rank_ff[i] + IDX_W'(1);
               end
            end
         end else if (access_word.opcode == OP_PUT) begin
            // Insert: drop the victim if full, age everyone, new entry at rank zero.
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (slot_vec[i]) begin
                  entry_key_in[i]   = access_word.lookup_key;
                  entry_value_in[i] = access_word.store_value;
                  entry_rank_in[i]  = '0;
                  entry_valid_in[i] = 1'b1;
               end else if (valid_mid[i]) begin
                  entry_rank_in[i]  = entry_rank_ff[i] + IDX_W'(1);
               end else begin
                  entry_rank_in[i]  = '0;
                  entry_valid_in[i] = 1'b0;
               end
            end
            used_in = used_ff + CNT_W'(1) - CNT_W'(did_evict);
         end
      end
   end

   // Result of the word being processed.
   always_comb begin
      result_word.found   = match.found;
      result_word.evicted = 1'b0;
      if (access_word.opcode == OP_PUT) begin
         result_word.read_value = '0;
         result_word.evicted    = !match.found && did_evict;
      end else if (match.found) begin
         result_word.read_value = match.hit_value;
      end else begin
         result_word.read_value = MISS_VALUE;
      end
   end

   // Control state of the table.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         entry_rank_ff  <= '0;
         used_ff        <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         entry_rank_ff  <= entry_rank_in;
         used_ff        <= used_in;
      end
   end

   // Keys and values are only read behind a valid bit.
   always_ff @(posedge clock) begin
      entry_key_ff   <= entry_key_in;
      entry_value_ff <= entry_value_in;
   end

endmodule

[src/lru_key_value_cache.sv]
// Channel   Direction  Payload         Handshake
// req_      in         req_word_type   req_valid / req_stall
// rsp_      out        rsp_word_type   rsp_valid / rsp_stall
// csr_      in         capacity (5b)   csr_write_enable, no read-back
//
// One word is accepted per cycle while req_stall is low. The tag compare and the rank
// update run while a word sits in the input register, and the result is registered
// in the output register when the processing stage advances.
// Reset is synchronous; it empties the table and sets the capacity to 16.
// A stalled response holds the processing stage, and req_stall follows.
module lru_key_value_cache
   import lkv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  req_word_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_word_type       rsp_data,
   input  logic               csr_write_enable,
   input  logic [CAP_W-1:0]   csr_write_data
);

   req_word_type     in_word_ff;
   req_word_type     in_word_in;
   logic             in_valid_ff;
   logic             in_valid_in;
   rsp_word_type     rsp_word_ff;
   rsp_word_type     rsp_word_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;

   logic             accept_req;
   logic             advance;
   logic [CNT_W-1:0] capacity_eff;
   rsp_word_type     result_word;

   // Handshake: the processing stage moves when the output register is free.
   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign accept_req = req_valid && !req_stall;

   assign in_valid_in  = accept_req || (in_valid_ff && !advance);
   assign in_word_in   = accept_req ? req_data : in_word_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   assign rsp_word_in  = advance ? result_word : rsp_word_ff;
   assign capacity_in  = csr_write_enable ? csr_write_data : capacity_ff;

   // Capacity zero acts as one; anything above the table size saturates.
   always_comb begin
      if (capacity_ff == '0) begin
         capacity_eff = CNT_W'(1);
      end else if (32'(capacity_ff) > MAX_ENTRIES) begin
         capacity_eff = CNT_W'(MAX_ENTRIES);
      end else begin
         capacity_eff = CNT_W'(capacity_ff);
      end
   end

   lkv_table u_table (
      .clock       (clock),
      .reset       (reset),
      .access_en   (advance),
      .access_word (in_word_ff),
      .capacity    (capacity_eff),
      .result_word (result_word)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         capacity_ff  <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         capacity_ff  <= capacity_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

`ifndef SYNTHESIS
   // A response appears only after a word was waiting in the input register.
   a_rsp_from_input : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response without a pending input word");

   // An eviction only happens on an insert, never on a hit.
   a_evict_not_found : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.evicted) |-> !rsp_word_ff.found)
      else $error("eviction reported on a hit");

   // The input side is held back only by a full, stalled output register.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a stalled output");
`endif

endmodule

[test/lru_key_value_cache_tb.sv]
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
   import lkv_pkg::*;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   req_word_type       req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   rsp_word_type       rsp_data;
   logic               csr_write_enable;
   logic [CAP_W-1:0]   csr_write_data;

   // Shadow copy of the cache table, kept in step with every accepted word.
   logic [KEY_W-1:0]   shadow_key [MAX_ENTRIES];
   logic [VAL_W-1:0]   shadow_value [MAX_ENTRIES];
   bit                 shadow_valid [MAX_ENTRIES];
   int                 shadow_rank [MAX_ENTRIES];
   int                 shadow_used;
   logic [CAP_W-1:0]   shadow_capacity;

   // Responses still owed by the block, oldest first.
   rsp_word_type       owed_responses [$];
   int                 error_count;

   // Idle and stall controls shared by the test tasks and the driver processes.
   int                 req_gap_pct;
   int                 rsp_stall_pct;
   int                 hold_request;
   int                 hold_left;
   int                 stall_left;

   lru_key_value_cache DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length(input int pct);
      if ($urandom_range(99) >= pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   function automatic req_word_type access_word(input opcode_type op,
                                                input logic [KEY_W-1:0] key,
                                                input logic [VAL_W-1:0] value);
      req_word_type w;
      w.opcode      = op;
      w.lookup_key  = key;
      w.store_value = value;
      return w;
   endfunction

   // Move one entry to the front of the recency order.
   function automatic void promote_entry(input int idx);
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (shadow_valid[i] && i != idx && shadow_rank[i] < shadow_rank[idx])
            shadow_rank[i]++;
      end
      shadow_rank[idx] = 0;
   endfunction

   // Apply one access to the shadow table and return the response it must produce.
   function automatic rsp_word_type predict_access(input req_word_type w);
      rsp_word_type r;
      int hit;
      int oldest;
      int slot;
      int limit;
      hit = -1;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (hit < 0 && shadow_valid[i] && shadow_key[i] == w.lookup_key)
            hit = i;
      end
      r.found      = (hit >= 0);
      r.read_value = '0;
      r.evicted    = 1'b0;
      if (w.opcode == OP_GET) begin
         if (hit >= 0) begin
            r.read_value = shadow_value[hit];
            promote_entry(hit);
         end else begin
            r.read_value = MISS_VALUE;
         end
      end else if (hit >= 0) begin
         shadow_value[hit] = w.store_value;
         promote_entry(hit);
      end else begin
         // A zero capacity acts as one; anything above the table size saturates.
         limit = shadow_capacity;
         if (limit == 0) limit = 1;
         if (limit > MAX_ENTRIES) limit = MAX_ENTRIES;
         if (shadow_used >= limit) begin
            oldest = -1;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (shadow_valid[i] && (oldest < 0 || shadow_rank[i] > shadow_rank[oldest]))
                  oldest = i;
            end
            if (oldest >= 0) begin
               shadow_valid[oldest] = 1'b0;
               shadow_rank[oldest]  = 0;
               if (shadow_used > 0) shadow_used--;
               r.evicted = 1'b1;
            end
         end
         // The insert takes the lowest free entry and every other entry ages by one.
         slot = -1;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot < 0 && !shadow_valid[i]) slot = i;
         end
         if (slot >= 0) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               if (shadow_valid[i]) shadow_rank[i]++;
            end
            shadow_key[slot]   = w.lookup_key;
            shadow_value[slot] = w.store_value;
            shadow_valid[slot] = 1'b1;
            shadow_rank[slot]  = 0;
            shadow_used++;
         end
      end
      return r;
   endfunction

   // Offer one word after a random gap and record its prediction once accepted.
   task automatic send_word(input req_word_type w);
      int gap;
      gap = idle_length(req_gap_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      owed_responses.push_back(predict_access(w));
   endtask

   // Stop offering words and wait until every owed response has come back.
   task automatic drain_pipeline();
      if (req_valid) req_valid <= 1'b0;
      while (owed_responses.size() != 0) @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      shadow_capacity = value;
   endtask

   // Receiver: random stalls, plus a long hold-off when a test asks for one.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = idle_length(rsp_stall_pct);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted response word with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_responses.size() == 0) begin
            $error("response word arrived with no prediction pending");
            error_count++;
         end else begin
            want = owed_responses.pop_front();
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0b, actual %0b", want.found, rsp_data.found);
               error_count++;
            end
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %h, actual %h",
                      want.read_value, rsp_data.read_value);
               error_count++;
            end
            if (rsp_data.evicted !== want.evicted) begin
               $error("evicted: expected %0b, actual %0b", want.evicted, rsp_data.evicted);
               error_count++;
            end
         end
      end
   end

   // Extreme keys and values, hits, misses and an update, at the reset capacity.
   task automatic test_basic_access();
      send_word(access_word(OP_GET, 32'h0000_0000, 32'h1234_5678));
      send_word(access_word(OP_PUT, 32'h0000_0000, 32'h7FFF_FFFF));
      send_word(access_word(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF));
      send_word(access_word(OP_PUT, 32'h8000_0000, 32'h8000_0000));
      send_word(access_word(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      // A stored all-ones value must still report found.
      send_word(access_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000));
      send_word(access_word(OP_PUT, 32'h0000_0000, 32'h0000_0000));
      send_word(access_word(OP_GET, 32'h8000_0000, 32'h7FFF_FFFF));
      drain_pipeline();
   endtask

   // Capacity lowered below the number of entries held, then the zero capacity.
   task automatic test_capacity_shrink();
      write_capacity(CAP_W'(2));
      send_word(access_word(OP_PUT, 32'h0000_0005, 32'h0000_0055));
      send_word(access_word(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000));
      send_word(access_word(OP_GET, 32'h0000_0000, 32'h0000_0000));
      send_word(access_word(OP_PUT, 32'h0000_0006, 32'h0000_0066));
      send_word(access_word(OP_GET, 32'h8000_0000, 32'h0000_0000));
      drain_pipeline();
      write_capacity(CAP_W'(0));
      send_word(access_word(OP_PUT, 32'h0000_0007, 32'hA5A5_A5A5));
      send_word(access_word(OP_PUT, 32'h0000_0008, 32'h5A5A_5A5A));
      send_word(access_word(OP_GET, 32'h0000_0007, 32'h0000_0000));
      drain_pipeline();
   endtask

   // Random gets and puts over a key set a little larger than the capacity.
   task automatic test_random_traffic(input logic [CAP_W-1:0] capacity, input int items,
                                      input int gap_pct, input int stall_pct);
      logic [KEY_W-1:0] key_pool [$];
      int               pool_size;
      logic [KEY_W-1:0] key;
      opcode_type       op;
      drain_pipeline();
      write_capacity(capacity);
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      pool_size = (capacity == 0) ? 1 : (capacity > MAX_ENTRIES ? MAX_ENTRIES : capacity);
      pool_size = pool_size + $urandom_range(4, 1);
      for (int i = 0; i < pool_size; i++) key_pool.push_back($urandom);
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(9) == 0) key = $urandom;
         else key = key_pool[$urandom_range(pool_size - 1)];
         op = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
         send_word(access_word(op, key, $urandom));
      end
      drain_pipeline();
   endtask

   // The receiver holds off for a long stretch while words keep coming.
   task automatic test_backpressure();
      logic [KEY_W-1:0] key_pool [$];
      drain_pipeline();
      write_capacity(CAP_W'(8));
      req_gap_pct   = 0;
      rsp_stall_pct = 10;
      for (int i = 0; i < 10; i++) key_pool.push_back($urandom);
      hold_request = 150;
      for (int n = 0; n < 100; n++) begin
         send_word(access_word($urandom_range(1) ? OP_PUT : OP_GET,
                               key_pool[$urandom_range(9)], $urandom));
      end
      drain_pipeline();
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      error_count      = 0;
      req_gap_pct      = 20;
      rsp_stall_pct    = 20;
      hold_request     = 0;
      hold_left        = 0;
      stall_left       = 0;
      shadow_used      = 0;
      shadow_capacity  = CAP_RESET;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         shadow_key[i]   = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i]  = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_basic_access();
      test_capacity_shrink();
      test_random_traffic(CAP_W'(31), 300, 30, 30);
      test_random_traffic(CAP_W'(1), 150, 0, 0);
      test_random_traffic(CAP_W'(4), 250, 50, 50);
      test_random_traffic(CAP_W'($urandom_range(31)), 250, 20, 20);
      test_random_traffic(CAP_W'(16), 250, 0, 40);
      test_random_traffic(CAP_W'(17), 150, 40, 0);
      test_backpressure();

      // Give any stray response time to show up before the verdict.
      repeat (8) @(posedge clock);
      if (error_count == 0 && owed_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[files.f]
src/lkv_pkg.sv
src/lkv_match.sv
src/lkv_table.sv
src/lru_key_value_cache.sv
test/lru_key_value_cache_tb.sv
